// ===== sv/itc_pkg.sv =====
// Shared codes and field widths for the interval timer channel.
package itc_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    localparam logic [1:0] CHAN_0    = 2'b00;
    localparam logic [1:0] ACC_LATCH = 2'b00;
    localparam logic [1:0] ACC_LOHI  = 2'b11;

    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_RATE_ALT = 3'd6;
    localparam logic [2:0] MODE_STROBE   = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_ONE  = 16'd1;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 16'd0;

endpackage

// ===== sv/interval_timer_channel.sv =====
// Top level: one 8254-style counter channel driven by tick and bus transactions.
// A result passes through the input register, then the result register, and is held
// there while the output side stalls. Throughput: one transaction per cycle unless the
// output side stalls; the count update is one 16-bit decrement and compare.
// Reset (synchronous, active low): both stages empty, counter stopped, OUT high, all
// counter registers cleared.
module interval_timer_channel
    import itc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] write_data
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] action, [2] port_sel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [7:0] read_data, [8] out_level,
                                                 // [9] terminal_pulse, [15:10] zero
);

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_in_action;
    logic                r_in_port;
    logic [BYTE_W-1:0]   r_in_data;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_reload, n_reload;
    logic [BYTE_W-1:0]  r_low_hold, n_low_hold;
    logic               r_hi_wr, n_hi_wr;
    logic               r_hi_rd, n_hi_rd;
    logic [COUNT_W-1:0] r_latched, n_latched;
    logic               r_latch_held, n_latch_held;
    logic               r_strobe_mode, n_strobe_mode;
    logic               r_load_pend, n_load_pend;
    logic               r_counting, n_counting;
    logic               r_out_line, n_out_line;
    logic               r_strobe_done, n_strobe_done;

    logic               advance;
    logic               fire;
    logic [BYTE_W-1:0]  rd_byte;
    logic               pulse;
    logic [COUNT_W-1:0] dec;
    logic [COUNT_W-1:0] src;
    logic [1:0]         cw_chan;
    logic [1:0]         cw_acc;
    logic [2:0]         cw_mode;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign dec     = r_count - COUNT_ONE;
    assign src     = r_latch_held ? r_latched : r_count;
    assign cw_chan = r_in_data[7:6];
    assign cw_acc  = r_in_data[5:4];
    assign cw_mode = r_in_data[3:1];

    always_comb begin
        n_count       = r_count;
        n_reload      = r_reload;
        n_low_hold    = r_low_hold;
        n_hi_wr       = r_hi_wr;
        n_hi_rd       = r_hi_rd;
        n_latched     = r_latched;
        n_latch_held  = r_latch_held;
        n_strobe_mode = r_strobe_mode;
        n_load_pend   = r_load_pend;
        n_counting    = r_counting;
        n_out_line    = r_out_line;
        n_strobe_done = r_strobe_done;
        rd_byte       = '0;
        pulse         = 1'b0;
        case (r_in_action)
            ACT_TICK: begin
                if (r_load_pend) begin
                    n_count       = r_reload;
                    n_load_pend   = 1'b0;
                    n_counting    = 1'b1;
                    n_strobe_done = 1'b0;
                    n_out_line    = 1'b1;
                end else if (r_counting) begin
                    if (!r_strobe_mode) begin
                        if (!r_out_line) begin
                            n_count    = r_reload;
                            n_out_line = 1'b1;
                        end else begin
                            n_count = dec;
                            if (dec == COUNT_ONE) begin
                                n_out_line = 1'b0;
                                pulse      = 1'b1;
                            end
                        end
                    end else begin
                        n_count = dec;
                        if (dec == COUNT_ZERO && !r_strobe_done) begin
                            n_out_line    = 1'b0;
                            n_strobe_done = 1'b1;
                            pulse         = 1'b1;
                        end else begin
                            n_out_line = 1'b1;
                        end
                    end
                end
            end
            ACT_WRITE: begin
                if (r_in_port == PORT_CTRL) begin
                    if (cw_chan == CHAN_0) begin
                        if (cw_acc == ACC_LATCH) begin
                            if (!r_latch_held) begin
                                n_latched    = r_count;
                                n_latch_held = 1'b1;
                            end
                        end else if (cw_acc == ACC_LOHI && !r_in_data[0] &&
                                     (cw_mode == MODE_RATE || cw_mode == MODE_RATE_ALT ||
                                      cw_mode == MODE_STROBE)) begin
                            n_strobe_mode = (cw_mode == MODE_STROBE);
                            n_hi_wr       = 1'b0;
                            n_hi_rd       = 1'b0;
                            n_latch_held  = 1'b0;
                            n_load_pend   = 1'b0;
                            n_counting    = 1'b0;
                            n_out_line    = 1'b1;
                            n_strobe_done = 1'b0;
                        end
                    end
                end else begin
                    if (!r_hi_wr) begin
                        n_low_hold = r_in_data;
                        n_hi_wr    = 1'b1;
                    end else begin
                        n_reload    = {r_in_data, r_low_hold};
                        n_hi_wr     = 1'b0;
                        n_load_pend = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                if (r_in_port == PORT_DATA) begin
                    if (!r_hi_rd) begin
                        n_hi_rd = 1'b1;
                        rd_byte = src[BYTE_W-1:0];
                    end else begin
                        n_hi_rd      = 1'b0;
                        n_latch_held = 1'b0;
                        rd_byte      = src[COUNT_W-1:BYTE_W];
                    end
                end
            end
            default: begin
                rd_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser[ACTION_W-1:0];
            r_in_port   <= s_axis_tuser[ACTION_W];
            r_in_data   <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {{(OUT_DATA_W-BYTE_W-2){1'b0}}, pulse, n_out_line, rd_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_reload      <= '0;
            r_low_hold    <= '0;
            r_hi_wr       <= 1'b0;
            r_hi_rd       <= 1'b0;
            r_latched     <= '0;
            r_latch_held  <= 1'b0;
            r_strobe_mode <= 1'b0;
            r_load_pend   <= 1'b0;
            r_counting    <= 1'b0;
            r_out_line    <= 1'b1;
            r_strobe_done <= 1'b0;
        end else if (fire) begin
            r_count       <= n_count;
            r_reload      <= n_reload;
            r_low_hold    <= n_low_hold;
            r_hi_wr       <= n_hi_wr;
            r_hi_rd       <= n_hi_rd;
            r_latched     <= n_latched;
            r_latch_held  <= n_latch_held;
            r_strobe_mode <= n_strobe_mode;
            r_load_pend   <= n_load_pend;
            r_counting    <= n_counting;
            r_out_line    <= n_out_line;
            r_strobe_done <= n_strobe_done;
        end
    end

endmodule

// ===== sv/itc_checker.sv =====
// Port-level checks for the interval timer channel, bound to the top level.
module itc_checker
    import itc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pulse_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[BYTE_W+1] |-> !m_axis_tdata[BYTE_W])
        else $error("terminal pulse with output line high");

    a_pulse_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[BYTE_W+1] |-> m_axis_tdata[BYTE_W-1:0] == '0)
        else $error("terminal pulse with read data");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:BYTE_W+2] == '0)
        else $error("result padding not zero");

endmodule

bind interval_timer_channel itc_checker u_itc_checker (.*);

// ===== verif/interval_timer_channel_tb.sv =====
// Self-checking testbench for the interval timer channel: shadow counter, random bus traffic.
`timescale 1ns / 100ps

module interval_timer_channel_tb;
    import itc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              lvl;
        logic              pulse;
    } timer_result_t;

    class timer_channel_shadow;
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0] reload;
        logic [BYTE_W-1:0]  low_hold;
        logic               want_high_wr;
        logic               want_high_rd;
        logic [COUNT_W-1:0] latch_val;
        logic               latch_on;
        logic               strobe;
        logic               load_due;
        logic               running;
        logic               out_line;
        logic               strobe_fired;
        timer_result_t      due_results[$];
        int                 mismatches;

        function new();
            cnt          = COUNT_ZERO;
            reload       = COUNT_ZERO;
            low_hold     = '0;
            want_high_wr = 1'b0;
            want_high_rd = 1'b0;
            latch_val    = COUNT_ZERO;
            latch_on     = 1'b0;
            strobe       = 1'b0;
            load_due     = 1'b0;
            running      = 1'b0;
            out_line     = 1'b1;
            strobe_fired = 1'b0;
            mismatches   = 0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void control_write(logic [BYTE_W-1:0] w);
            if (w[7:6] != CHAN_0) return;
            if (w[5:4] == ACC_LATCH) begin
                if (!latch_on) begin
                    latch_val = cnt;
                    latch_on  = 1'b1;
                end
                return;
            end
            if (w[5:4] != ACC_LOHI || w[0]) return;
            if (w[3:1] == MODE_RATE || w[3:1] == MODE_RATE_ALT) strobe = 1'b0;
            else if (w[3:1] == MODE_STROBE) strobe = 1'b1;
            else return;
            want_high_wr = 1'b0;
            want_high_rd = 1'b0;
            latch_on     = 1'b0;
            load_due     = 1'b0;
            running      = 1'b0;
            out_line     = 1'b1;
            strobe_fired = 1'b0;
        endfunction

        function void data_write(logic [BYTE_W-1:0] w);
            if (!want_high_wr) begin
                low_hold     = w;
                want_high_wr = 1'b1;
            end else begin
                reload       = {w, low_hold};
                want_high_wr = 1'b0;
                load_due     = 1'b1;
            end
        endfunction

        function logic [BYTE_W-1:0] data_read();
            logic [COUNT_W-1:0] src;
            src = latch_on ? latch_val : cnt;
            if (!want_high_rd) begin
                want_high_rd = 1'b1;
                return src[7:0];
            end
            want_high_rd = 1'b0;
            latch_on     = 1'b0;
            return src[15:8];
        endfunction

        function logic advance_tick();
            if (load_due) begin
                cnt          = reload;
                load_due     = 1'b0;
                running      = 1'b1;
                strobe_fired = 1'b0;
                out_line     = 1'b1;
                return 1'b0;
            end
            if (!running) return 1'b0;
            if (!strobe) begin
                if (!out_line) begin
                    cnt      = reload;
                    out_line = 1'b1;
                end else begin
                    cnt = cnt - COUNT_ONE;
                    if (cnt == COUNT_ONE) begin
                        out_line = 1'b0;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            cnt = cnt - COUNT_ONE;
            if (cnt == COUNT_ZERO && !strobe_fired) begin
                out_line     = 1'b0;
                strobe_fired = 1'b1;
                return 1'b1;
            end
            out_line = 1'b1;
            return 1'b0;
        endfunction

        function void absorb_transaction(logic [ACTION_W-1:0] act, logic port,
                                         logic [BYTE_W-1:0] wd);
            timer_result_t r;
            r = '0;
            case (act)
                ACT_TICK: r.pulse = advance_tick();
                ACT_WRITE: begin
                    if (port == PORT_CTRL) control_write(wd);
                    else data_write(wd);
                end
                ACT_READ: begin
                    if (port == PORT_DATA) r.rd = data_read();
                end
                default: ;
            endcase
            r.lvl = out_line;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task compare_output(logic [OUT_DATA_W-1:0] d);
            timer_result_t e;
            if (due_results.size() == 0) begin
                report($sformatf("result %h arrived with nothing outstanding", d));
                return;
            end
            e = due_results.pop_front();
            if (d[7:0] !== e.rd)
                report($sformatf("read_data %h, predicted %h", d[7:0], e.rd));
            if (d[8] !== e.lvl)
                report($sformatf("out_level %b, predicted %b", d[8], e.lvl));
            if (d[9] !== e.pulse)
                report($sformatf("terminal_pulse %b, predicted %b", d[9], e.pulse));
            if (d[15:10] !== '0)
                report($sformatf("padding bits %b not zero", d[15:10]));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] write_data
    logic [IN_USER_W-1:0]  s_axis_tuser;   // [1:0] action, [2] port_sel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] read_data, [8] out_level,
                                           // [9] terminal_pulse, [15:10] zero

    timer_channel_shadow shadow;
    logic idle_en;
    int   item_count;
    int   cycles;

    interval_timer_channel uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL interval_timer_channel");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) shadow.compare_output(m_axis_tdata);
    end

    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    function automatic logic [BYTE_W-1:0] ctrl_word(logic [1:0] chan, logic [1:0] acc,
                                                    logic [2:0] mode, logic bcd);
        return {chan, acc, mode, bcd};
    endfunction

    function automatic logic [COUNT_W-1:0] pick_reload();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel < 8) return COUNT_W'($urandom_range(1, 12));
        if (sel < 10) return COUNT_W'($urandom);
        case ($urandom_range(0, 3))
            0: return COUNT_ZERO;
            1: return COUNT_ONE;
            2: return 16'h0002;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send(input logic [ACTION_W-1:0] act, input logic port,
                        input logic [BYTE_W-1:0] wd);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {port, act};
        s_axis_tdata  = wd;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.absorb_transaction(act, port, wd);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic load_reload(input logic [COUNT_W-1:0] value);
        send(ACT_WRITE, PORT_DATA, value[7:0]);
        send(ACT_WRITE, PORT_DATA, value[15:8]);
    endtask

    task automatic ticks(input int n);
        repeat (n) send(ACT_TICK, PORT_DATA, 8'h00);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (shadow.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic run_directed();
        ticks(1);
        send(ACT_NONE, PORT_DATA, 8'hFF);
        send(ACT_READ, PORT_CTRL, 8'h00);
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, MODE_RATE, 1'b0));
        load_reload(16'h0002);
        ticks(3);
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LATCH, 3'd0, 1'b0));
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LATCH, 3'd0, 1'b0));
        ticks(1);
        send(ACT_READ, PORT_DATA, 8'h00);
        send(ACT_READ, PORT_DATA, 8'h00);
        send(ACT_WRITE, PORT_CTRL, ctrl_word(2'b11, ACC_LATCH, 3'd0, 1'b0));
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, 2'b01, MODE_RATE, 1'b0));
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, MODE_RATE, 1'b1));
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, 3'd0, 1'b0));
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, MODE_STROBE, 1'b0));
        load_reload(16'h0001);
        ticks(3);
        send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, MODE_RATE_ALT, 1'b0));
        load_reload(16'h0001);
        ticks(2);
    endtask

    task automatic run_sequence();
        logic [2:0]         mode;
        logic [COUNT_W-1:0] value;
        int                 n_steps;
        case ($urandom_range(0, 2))
            0: mode = MODE_RATE;
            1: mode = MODE_RATE_ALT;
            default: mode = MODE_STROBE;
        endcase
        if ($urandom_range(0, 7) != 0)
            send(ACT_WRITE, PORT_CTRL, ctrl_word(CHAN_0, ACC_LOHI, mode, 1'b0));
        value = pick_reload();
        send(ACT_WRITE, PORT_DATA, value[7:0]);
        if ($urandom_range(0, 15) != 0) send(ACT_WRITE, PORT_DATA, value[15:8]);
        n_steps = $urandom_range(4, 40);
        repeat (n_steps) begin
            case ($urandom_range(0, 19))
                0: send(ACT_WRITE, PORT_CTRL,
                        ctrl_word(CHAN_0, ACC_LATCH, 3'($urandom), 1'($urandom)));
                1, 2: send(ACT_READ, PORT_DATA, 8'($urandom));
                3: load_reload(pick_reload());
                4: send(2'($urandom), 1'($urandom), 8'($urandom));
                5: begin
                    if ($urandom_range(0, 3) == 0)
                        send(ACT_WRITE, PORT_CTRL,
                             ctrl_word(2'($urandom), 2'($urandom), 3'($urandom), 1'($urandom)));
                    else
                        send(ACT_WRITE, PORT_CTRL, 8'($urandom));
                end
                default: send(ACT_TICK, 1'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin
        logic drained;
        shadow        = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_en       = 1'b0;
        item_count    = 0;
        cycles        = 0;
        drained       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        while (item_count < 1450) begin
            idle_en = ($urandom_range(0, 3) != 0);
            run_sequence();
            if ((!drained && item_count >= 700) || $urandom_range(0, 24) == 0) begin
                drain();
                drained = 1'b1;
            end
        end

        idle_en = 1'b0;
        while (item_count < 1700) run_sequence();

        drain();
        repeat (8) @(negedge i_clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("PASS interval_timer_channel");
        else
            $display("FAIL interval_timer_channel");
        $finish;
    end

endmodule
